### hdl/alv_pkg.sv
`default_nettype none
package alv_pkg;

	localparam logic signed [15:0] LEVEL_FLOOR = -16'sd23040;
	localparam logic [17:0] TEN_LOG10_2_Q16 = 18'd197283;
	localparam logic [16:0] ALPHA_ONE = 17'd65536;

	typedef enum logic [2:0] {
		REG_ENABLED = 3'd0,
		REG_ALPHA   = 3'd1,
		REG_QUIET   = 3'd2,
		REG_LOUD    = 3'd3,
		REG_MIN_VOL = 3'd4,
		REG_MAX_VOL = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic               enabled;
		logic [16:0]        alpha;
		logic signed [15:0] quiet;
		logic signed [15:0] loud;
		logic [15:0]        min_vol;
		logic [15:0]        max_vol;
	} cfg_t;

endpackage
`default_nettype wire

### hdl/ambient_level_to_volume.sv
// Ambient level meter: one microphone sample beat per cycle is squared and summed; the beat
// marked last of a buffer closes the buffer and, after the meter math, gives one result beat
// (smoothed Q8.8 dBFS level, Q0.16 target volume, updated flag). Sample beats are taken every
// cycle while fewer than two closed buffers wait. A closed buffer may pass through the shared
// iterative divider (for the mean square and again for the volume mapping), the normalize
// shifter and the 16-step log2 squaring loop (SUM_W = SQUARE_BITS + clog2(MAX_FRAMES+1),
// NW = max(SUM_W,32), DW = max(SUM_W,33)). A discarded buffer skips the level math and
// uses the divider only when the volume mapping needs it.
`default_nettype none
module ambient_level_to_volume #(
	parameter int MAX_FRAMES  = 1024,
	parameter int SQUARE_BITS = 24
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [4:0]          paddr,
	input  wire [31:0]         pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire signed [31:0]  sample,
	input  wire                last_of_buffer,
	input  wire                speaker_busy,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [15:0] level_dbfs,
	output logic [15:0]        target_volume,
	output logic               updated
);
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int SUM_W = SQUARE_BITS + CNT_W;
	localparam int EW    = SUM_W + CNT_W + 1;

	alv_pkg::cfg_t cfg_q;
	logic          push, pop, q_full, q_empty;
	logic [EW-1:0] entry, q_data;
	logic [2:0]    ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b1;
			cfg_q.alpha   <= 17'd6554;
			cfg_q.quiet   <= -16'sd12800;
			cfg_q.loud    <= -16'sd6400;
			cfg_q.min_vol <= 16'd26214;
			cfg_q.max_vol <= 16'd55706;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				alv_pkg::REG_ENABLED: cfg_q.enabled <= pwdata[0];
				alv_pkg::REG_ALPHA:   cfg_q.alpha   <= pwdata[16:0];
				alv_pkg::REG_QUIET:   cfg_q.quiet   <= pwdata[15:0];
				alv_pkg::REG_LOUD:    cfg_q.loud    <= pwdata[15:0];
				alv_pkg::REG_MIN_VOL: cfg_q.min_vol <= pwdata[15:0];
				alv_pkg::REG_MAX_VOL: cfg_q.max_vol <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (ridx)
			alv_pkg::REG_ENABLED: prdata = {31'd0, cfg_q.enabled};
			alv_pkg::REG_ALPHA:   prdata = {15'd0, cfg_q.alpha};
			alv_pkg::REG_QUIET:   prdata = {{16{cfg_q.quiet[15]}}, cfg_q.quiet};
			alv_pkg::REG_LOUD:    prdata = {{16{cfg_q.loud[15]}}, cfg_q.loud};
			alv_pkg::REG_MIN_VOL: prdata = {16'd0, cfg_q.min_vol};
			alv_pkg::REG_MAX_VOL: prdata = {16'd0, cfg_q.max_vol};
			default:              prdata = '0;
		endcase
	end

	alv_front #(
		.MAX_FRAMES  (MAX_FRAMES),
		.SQUARE_BITS (SQUARE_BITS),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.last_of_buffer (last_of_buffer),
		.speaker_busy   (speaker_busy),
		.enabled        (cfg_q.enabled),
		.push           (push),
		.entry          (entry),
		.q_full         (q_full)
	);

	alv_fifo #(.W(EW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.rdata  (q_data)
	);

	alv_back #(
		.SQUARE_BITS (SQUARE_BITS),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_data        (q_data),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.level_dbfs    (level_dbfs),
		.target_volume (target_volume),
		.updated       (updated)
	);
endmodule
`default_nettype wire

### hdl/alv_fifo.sv
`default_nettype none
module alv_fifo #(
	parameter int W = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire [W-1:0]  wdata,
	output logic         full,
	input  wire          pop,
	output logic         empty,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full && !pop))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue underflow");
endmodule
`default_nettype wire

### hdl/alv_div.sv
`default_nettype none
module alv_div #(
	parameter int DW = 36,
	parameter int VW = 17
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	input  wire [DW-1:0]  dividend,
	input  wire [VW-1:0]  divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial    = {rem_q[VW-1:0], dvd_q[DW-1]};
	assign fits     = (trial >= {1'b0, dvs_q});
	assign quotient = dvd_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			dvd_q <= {dvd_q[DW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

### hdl/alv_front.sv
`default_nettype none
module alv_front #(
	parameter int MAX_FRAMES  = 1024,
	parameter int SQUARE_BITS = 24,
	parameter int CNT_W       = 11,
	parameter int SUM_W       = 35
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire signed [31:0]        sample,
	input  wire                      last_of_buffer,
	input  wire                      speaker_busy,
	input  wire                      enabled,
	output logic                     push,
	output logic [SUM_W+CNT_W:0]     entry,
	input  wire                      q_full
);
	localparam int SH = 62 - SQUARE_BITS;

	logic               v_s1, last_s1, busy_s1;
	logic [31:0]        mag_s1;
	logic               v_s2, last_s2, busy_s2;
	logic [SQUARE_BITS:0] sq_s2;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               advance, room;
	logic [63:0]        prod;
	logic [SUM_W-1:0]   sum_n;
	logic [CNT_W-1:0]   cnt_n;

	assign advance  = !(v_s2 && last_s2 && q_full);
	assign in_ready = advance;
	assign prod     = mag_s1 * mag_s1;
	assign room     = (cnt_q < CNT_W'(MAX_FRAMES));
	assign sum_n    = sum_q + (room ? SUM_W'(sq_s2) : '0);
	assign cnt_n    = cnt_q + CNT_W'(room);
	assign push     = advance && v_s2 && last_s2;
	assign entry    = {sum_n, cnt_n, !enabled || busy_s2};

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s1  <= sample[31] ? 32'(-sample) : 32'(sample);
			last_s1 <= last_of_buffer;
			busy_s1 <= speaker_busy;
			sq_s2   <= prod[SH +: SQUARE_BITS + 1];
			last_s2 <= last_s1;
			busy_s2 <= busy_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			if (v_s2) begin
				sum_q <= last_s2 ? '0 : sum_n;
				cnt_q <= last_s2 ? '0 : cnt_n;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_FRAMES))
		else $error("frame count beyond limit");
endmodule
`default_nettype wire

### hdl/alv_back.sv
`default_nettype none
module alv_back #(
	parameter int SQUARE_BITS = 24,
	parameter int CNT_W       = 11,
	parameter int SUM_W       = 35
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire alv_pkg::cfg_t        cfg,
	input  wire                       q_empty,
	input  wire [SUM_W+CNT_W:0]       q_data,
	output logic                      pop,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic signed [15:0]        level_dbfs,
	output logic [15:0]               target_volume,
	output logic                      updated
);
	localparam int NW  = (SUM_W > 32) ? SUM_W : 32;
	localparam int PW  = $clog2(NW);
	localparam int DDW = (SUM_W > 33) ? SUM_W : 33;
	localparam int DVW = (CNT_W > 17) ? CNT_W : 17;
	localparam int LW  = PW + 18;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_DIV_LVL = 13'b0000000000010,
		S_NORM    = 13'b0000000000100,
		S_SQ_MUL  = 13'b0000000001000,
		S_SQ_CHK  = 13'b0000000010000,
		S_DB_MUL  = 13'b0000000100000,
		S_DB_FIN  = 13'b0000001000000,
		S_EMA_MUL = 13'b0000010000000,
		S_EMA_FIN = 13'b0000100000000,
		S_VOL_MUL = 13'b0001000000000,
		S_VOL_DIV = 13'b0010000000000,
		S_VOL_FIN = 13'b0100000000000,
		S_OUT     = 13'b1000000000000
	} state_t;

	state_t                  state_q;
	logic                    disc_q;
	logic [NW-1:0]           norm_q;
	logic [PW-1:0]           p_q;
	logic [31:0]             x_q;
	logic [15:0]             frac_q;
	logic [3:0]              it_q;
	logic [63:0]             sqp_q;
	logic [LW+17:0]          dbp_q;
	logic signed [15:0]      lvl_q;
	logic signed [15:0]      s_q;
	logic signed [34:0]      emap_q;
	logic signed [33:0]      volp_q;
	logic [15:0]             vol_q;

	logic                    div_start, div_done;
	logic [DDW-1:0]          div_dvd, quot;
	logic [DVW-1:0]          div_dvs;

	logic [32:0]             sq_t;
	logic signed [PW+1:0]    pd;
	logic signed [LW-1:0]    l2;
	logic [LW-1:0]           l2_mag;
	logic [LW+17:0]          db_r;
	logic [16:0]             alpha_c;
	logic signed [16:0]      ema_diff;
	logic [34:0]             ema_mag;
	logic [18:0]             ema_q;
	logic signed [17:0]      s_next;
	logic signed [16:0]      num, den, vdif;
	logic [33:0]             vmag;
	logic [16:0]             vq;

	alv_div #(.DW(DDW), .VW(DVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (quot)
	);

	assign sq_t     = sqp_q[63:31];
	assign pd       = $signed({2'b00, p_q}) - (PW + 2)'(SQUARE_BITS);
	assign l2       = {pd, frac_q};
	assign l2_mag   = LW'(-l2);
	assign db_r     = (dbp_q + (LW + 18)'(1 << 23)) >> 24;
	assign alpha_c  = (cfg.alpha > alv_pkg::ALPHA_ONE) ? alv_pkg::ALPHA_ONE : cfg.alpha;
	assign ema_diff = 17'(lvl_q) - 17'(s_q);
	assign ema_mag  = emap_q[34] ? 35'(-emap_q) : 35'(emap_q);
	assign ema_q    = 19'((ema_mag + 35'd32768) >> 16);
	assign s_next   = emap_q[34] ? 18'(s_q) - 18'(ema_q) : 18'(s_q) + 18'(ema_q);
	assign num      = 17'(s_q) - 17'(cfg.quiet);
	assign den      = 17'(cfg.loud) - 17'(cfg.quiet);
	assign vdif     = $signed({1'b0, cfg.max_vol}) - $signed({1'b0, cfg.min_vol});
	assign vmag     = volp_q[33] ? 34'(-volp_q) : 34'(volp_q);
	assign vq       = quot[16:0];

	always_comb begin
		div_start = 1'b0;
		div_dvd   = DDW'(q_data[SUM_W+CNT_W:CNT_W+1]);
		div_dvs   = DVW'(q_data[CNT_W:1]);
		if (state_q == S_IDLE) begin
			div_start = !q_empty && !q_data[0];
		end else if (state_q == S_VOL_DIV) begin
			div_start = 1'b1;
			div_dvd   = DDW'(vmag + 34'(den[16:1]));
			div_dvs   = DVW'(den);
		end
	end

	assign pop = (state_q == S_IDLE) && !q_empty;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				disc_q <= q_data[0];
			end
			S_DIV_LVL: begin
				norm_q <= NW'(quot);
				p_q    <= PW'(NW - 1);
				if (div_done && quot == '0) begin
					lvl_q <= alv_pkg::LEVEL_FLOOR;
				end
			end
			S_NORM: begin
				if (norm_q[NW-1]) begin
					x_q    <= norm_q[NW-1 -: 32];
					frac_q <= '0;
					it_q   <= '0;
				end else begin
					norm_q <= {norm_q[NW-2:0], 1'b0};
					p_q    <= p_q - 1'b1;
				end
			end
			S_SQ_MUL: begin
				sqp_q <= x_q * x_q;
			end
			S_SQ_CHK: begin
				x_q    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
				frac_q <= {frac_q[14:0], sq_t[32]};
				it_q   <= it_q + 1'b1;
			end
			S_DB_MUL: begin
				dbp_q <= (LW + 18)'(l2_mag) * (LW + 18)'(alv_pkg::TEN_LOG10_2_Q16);
				if (!pd[PW+1]) begin
					lvl_q <= '0;
				end
			end
			S_DB_FIN: begin
				lvl_q <= (db_r > (LW + 18)'(23040)) ? alv_pkg::LEVEL_FLOOR : -$signed(db_r[15:0]);
			end
			S_EMA_MUL: begin
				emap_q <= $signed({1'b0, alpha_c}) * ema_diff;
			end
			S_VOL_MUL: begin
				volp_q <= num * vdif;
				if (cfg.loud <= cfg.quiet || num <= 17'sd0) begin
					vol_q <= cfg.min_vol;
				end else if (num >= den) begin
					vol_q <= cfg.max_vol;
				end
			end
			S_VOL_FIN: begin
				if (div_done) begin
					vol_q <= volp_q[33] ? cfg.min_vol - vq[15:0] : cfg.min_vol + vq[15:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			s_q           <= alv_pkg::LEVEL_FLOOR;
			out_valid     <= 1'b0;
			level_dbfs    <= alv_pkg::LEVEL_FLOOR;
			target_volume <= '0;
			updated       <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= q_data[0] ? S_VOL_MUL : S_DIV_LVL;
					end
				end
				S_DIV_LVL: begin
					if (div_done) begin
						state_q <= (quot == '0) ? S_EMA_MUL : S_NORM;
					end
				end
				S_NORM: begin
					if (norm_q[NW-1]) begin
						state_q <= S_SQ_MUL;
					end
				end
				S_SQ_MUL: state_q <= S_SQ_CHK;
				S_SQ_CHK: state_q <= (it_q == 4'd15) ? S_DB_MUL : S_SQ_MUL;
				S_DB_MUL: state_q <= pd[PW+1] ? S_DB_FIN : S_EMA_MUL;
				S_DB_FIN: state_q <= S_EMA_MUL;
				S_EMA_MUL: state_q <= S_EMA_FIN;
				S_EMA_FIN: begin
					s_q     <= s_next[15:0];
					state_q <= S_VOL_MUL;
				end
				S_VOL_MUL: begin
					if (cfg.loud <= cfg.quiet || num <= 17'sd0 || num >= den) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_VOL_DIV;
					end
				end
				S_VOL_DIV: state_q <= S_VOL_FIN;
				S_VOL_FIN: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid     <= 1'b1;
						level_dbfs    <= s_q;
						target_volume <= vol_q;
						updated       <= !disc_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		s_q >= alv_pkg::LEVEL_FLOOR && s_q <= 16'sd0)
		else $error("smoothed level out of range");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != S_IDLE)
		else $error("popped beat not taken up");
	a_out_new: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (!out_valid || out_ready)) |=> out_valid && state_q == S_IDLE)
		else $error("result not presented");
endmodule
`default_nettype wire

### verif/level_checker.sv
`default_nettype none
module level_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [4:0]         paddr,
	input  wire [31:0]        pwdata,
	input  wire               pready,
	input  wire               in_valid,
	input  wire               in_ready,
	input  wire signed [31:0] sample,
	input  wire               last_of_buffer,
	input  wire               speaker_busy,
	input  wire               out_valid,
	input  wire               out_ready,
	input  wire signed [15:0] level_dbfs,
	input  wire [15:0]        target_volume,
	input  wire               updated,
	output int                errors,
	output int                pending
);
	localparam int FRAME_CAP = 1024;
	localparam int SQ_BITS = 24;

	typedef struct packed {
		logic signed [15:0] level;
		logic [15:0]        volume;
		logic               upd;
	} meter_result_t;

	alv_pkg::cfg_t cfg;
	logic [63:0] sq_acc;
	int unsigned frames;
	logic signed [15:0] smooth;
	meter_result_t expected_q[$];

	assign pending = expected_q.size();

	function automatic longint round_div(longint p, longint d);
		longint unsigned m, q;
		m = (p < 0) ? -p : p;
		q = (m + d / 2) / d;
		return (p < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [15:0] dbfs_of(logic [63:0] m);
		int p;
		logic [63:0] x, frac, mag;
		longint l2, db;
		if (m == 0) return alv_pkg::LEVEL_FLOOR;
		p = 63;
		while (m[p] == 1'b0) p--;
		x = (p <= 31) ? (m << (31 - p)) : (m >> (p - 31));
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 31;
			frac = frac << 1;
			if (x >= 64'h1_0000_0000) begin
				x = x >> 1;
				frac[0] = 1'b1;
			end
		end
		l2 = (longint'(p) - SQ_BITS) * 65536 + longint'(frac);
		if (l2 >= 0) return 16'sd0;
		mag = -l2;
		db = -longint'((mag * 64'd197283 + (64'd1 << 23)) >> 24);
		if (db < alv_pkg::LEVEL_FLOOR) db = alv_pkg::LEVEL_FLOOR;
		return db[15:0];
	endfunction

	function automatic logic [15:0] volume_for(logic signed [15:0] s);
		longint num, den, v;
		if (cfg.loud <= cfg.quiet) return cfg.min_vol;
		num = longint'(s) - longint'(cfg.quiet);
		den = longint'(cfg.loud) - longint'(cfg.quiet);
		if (num <= 0) return cfg.min_vol;
		if (num >= den) return cfg.max_vol;
		v = longint'(cfg.min_vol)
			+ round_div(num * (longint'(cfg.max_vol) - longint'(cfg.min_vol)), den);
		return v[15:0];
	endfunction

	function automatic void accept_sample(logic signed [31:0] smp, logic last, logic busy);
		logic [63:0] mag;
		logic signed [15:0] lvl;
		longint a;
		meter_result_t r;
		mag = smp[31] ? (64'h1_0000_0000 - {32'd0, smp}) : {32'd0, smp};
		if (frames < FRAME_CAP) begin
			sq_acc += (mag * mag) >> (62 - SQ_BITS);
			frames++;
		end
		if (!last) return;
		r.upd = 1'b0;
		if (cfg.enabled && !busy) begin
			lvl = dbfs_of(sq_acc / frames);
			a = (cfg.alpha > alv_pkg::ALPHA_ONE) ? 65536 : longint'(cfg.alpha);
			smooth = smooth + 16'(round_div(a * (longint'(lvl) - longint'(smooth)), 65536));
			r.upd = 1'b1;
		end
		sq_acc = 0;
		frames = 0;
		r.level = smooth;
		r.volume = volume_for(smooth);
		expected_q.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		meter_result_t e;
		if (!arst_n) begin
			cfg = '{enabled: 1'b1, alpha: 17'd6554, quiet: -16'sd12800, loud: -16'sd6400,
				min_vol: 16'd26214, max_vol: 16'd55706};
			sq_acc = 0;
			frames = 0;
			smooth = alv_pkg::LEVEL_FLOOR;
			errors = 0;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (alv_pkg::reg_idx_t'(paddr[4:2]))
					alv_pkg::REG_ENABLED: cfg.enabled = pwdata[0];
					alv_pkg::REG_ALPHA:   cfg.alpha = pwdata[16:0];
					alv_pkg::REG_QUIET:   cfg.quiet = pwdata[15:0];
					alv_pkg::REG_LOUD:    cfg.loud = pwdata[15:0];
					alv_pkg::REG_MIN_VOL: cfg.min_vol = pwdata[15:0];
					alv_pkg::REG_MAX_VOL: cfg.max_vol = pwdata[15:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result beat level=%0d vol=%0d upd=%0b",
						$time, level_dbfs, target_volume, updated);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (level_dbfs !== e.level) begin
						$display("%0t: level_dbfs expected %0d actual %0d",
							$time, e.level, level_dbfs);
						errors++;
					end
					if (target_volume !== e.volume) begin
						$display("%0t: target_volume expected %0d actual %0d",
							$time, e.volume, target_volume);
						errors++;
					end
					if (updated !== e.upd) begin
						$display("%0t: updated expected %0b actual %0b",
							$time, e.upd, updated);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				accept_sample(sample, last_of_buffer, speaker_busy);
		end
	end
endmodule
`default_nettype wire

### verif/testbench.sv
`default_nettype none
module testbench;
	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_ready, last_of_buffer, speaker_busy;
	logic signed [31:0] sample;
	logic out_valid, out_ready, updated;
	logic signed [15:0] level_dbfs;
	logic [15:0] target_volume;
	int errors, pending;
	bit hold_output;
	int beats_sent;

	ambient_level_to_volume uut (.*);

	level_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic reg_write(alv_pkg::reg_idx_t idx, logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic send_beat(logic signed [31:0] smp, logic last, logic busy);
		int g;
		g = pick_gap();
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		sample <= smp;
		last_of_buffer <= last;
		speaker_busy <= busy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		beats_sent++;
	endtask

	function automatic logic signed [31:0] rand_sample(int amp_sel);
		logic signed [31:0] s;
		s = $urandom();
		case (amp_sel)
			0: s = s >>> 28;
			1: s = s >>> 20;
			2: s = s >>> 10;
			default: ;
		endcase
		return s;
	endfunction

	task automatic send_buffer(int len, int amp_sel, logic busy);
		for (int i = 0; i < len; i++)
			send_beat(rand_sample(amp_sel), i == len - 1, busy && (i == len - 1));
	endtask

	initial begin
		int r;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_output) begin
				out_ready <= 0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					out_ready <= 0;
					repeat ($urandom_range(10, 60)) @(negedge clk);
				end else begin
					out_ready <= (r >= 25);
				end
			end
		end
	end

	initial begin
		int r, phase_items;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; sample = 0; last_of_buffer = 0; speaker_busy = 0;
		hold_output = 0;
		beats_sent = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_beat(32'sh7fffffff, 0, 0);
		send_beat(-32'sh80000000, 1, 0);
		send_beat(0, 1, 0);
		send_beat(32'sd1, 0, 1);
		send_beat(-32'sd1, 1, 1);
		send_beat(32'sh40000000, 1, 0);
		send_beat(32'sh00001000, 1, 0);
		send_beat(32'sh00100000, 0, 1);
		send_beat(-32'sh00100000, 1, 0);
		send_beat(32'sh55555555, 1, 0);
		send_beat(-32'sh2aaaaaab, 1, 0);
		send_beat(32'sh00000100, 1, 0);
		drain();

		reg_write(alv_pkg::REG_ENABLED, 0);
		reg_write(alv_pkg::REG_ALPHA, 32'd65536);
		send_beat(32'sh7fffffff, 1, 0);
		drain();
		reg_write(alv_pkg::REG_ENABLED, 1);
		send_beat(32'sh7fffffff, 1, 0);
		send_beat(32'sh00010000, 1, 0);
		drain();
		reg_write(alv_pkg::REG_ALPHA, 32'h1ffff);
		reg_write(alv_pkg::REG_QUIET, 32'hffffa600);
		reg_write(alv_pkg::REG_LOUD, 32'hffffa600);
		send_beat(32'sh01000000, 1, 0);
		drain();
		reg_write(alv_pkg::REG_QUIET, 32'h0000);
		reg_write(alv_pkg::REG_LOUD, 32'hffffa600);
		reg_write(alv_pkg::REG_MIN_VOL, 32'hffff);
		reg_write(alv_pkg::REG_MAX_VOL, 32'h0000);
		send_beat(32'sh01000000, 1, 0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					reg_write(alv_pkg::REG_ALPHA, 6554);
					reg_write(alv_pkg::REG_QUIET, 32'hffffa600);
					reg_write(alv_pkg::REG_LOUD, 32'hffffe000);
					reg_write(alv_pkg::REG_MIN_VOL, 0);
					reg_write(alv_pkg::REG_MAX_VOL, 65535);
				end
				1: begin
					reg_write(alv_pkg::REG_ALPHA, 0);
					reg_write(alv_pkg::REG_MIN_VOL, 40000);
					reg_write(alv_pkg::REG_MAX_VOL, 1000);
				end
				2: begin
					reg_write(alv_pkg::REG_ALPHA, $urandom_range(0, 65536));
					reg_write(alv_pkg::REG_QUIET, 32'hffffa600);
					reg_write(alv_pkg::REG_LOUD, 32'h0000);
					reg_write(alv_pkg::REG_MIN_VOL, $urandom_range(0, 65535));
					reg_write(alv_pkg::REG_MAX_VOL, $urandom_range(0, 65535));
				end
				3: begin
					reg_write(alv_pkg::REG_ENABLED, 0);
				end
				4: begin
					reg_write(alv_pkg::REG_ENABLED, 1);
					reg_write(alv_pkg::REG_ALPHA, 32'h1ffff);
					reg_write(alv_pkg::REG_QUIET, 32'hffffce00);
					reg_write(alv_pkg::REG_LOUD, 32'hffffe700);
				end
				default: begin
					reg_write(alv_pkg::REG_ALPHA, 30000);
					reg_write(alv_pkg::REG_QUIET, 32'h8000);
					reg_write(alv_pkg::REG_LOUD, 32'h7fff);
				end
			endcase
			phase_items = (ph == 3) ? 40 : 120;
			if (ph == 2) begin
				fork
					begin
						hold_output = 1;
						repeat (800) @(negedge clk);
						hold_output = 0;
					end
				join_none
			end
			r = beats_sent + phase_items;
			while (beats_sent < r)
				send_buffer($urandom_range(1, 8), $urandom_range(0, 3),
					$urandom_range(0, 9) == 0);
			drain();
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

### ambient_level_to_volume.f
hdl/alv_pkg.sv
hdl/alv_fifo.sv
hdl/alv_div.sv
hdl/alv_front.sv
hdl/alv_back.sv
hdl/ambient_level_to_volume.sv
verif/level_checker.sv
verif/testbench.sv
